FILE: rtl/core/fpsq_pkg.sv
package fpsq_pkg;

    localparam int unsigned RadicandWidth = 32;
    localparam int unsigned RootWidth     = 24;
    localparam int unsigned FracBitsDflt  = 16;

    // any of the top twelve radicand bits set selects the high start bit
    localparam logic [RadicandWidth-1:0] TopTwelveMask = 32'hFFF0_0000;
    localparam logic [RadicandWidth-1:0] StartHigh     = 32'h4000_0000;
    localparam logic [RadicandWidth-1:0] StartLow      = 32'h0004_0000;

    typedef logic [RadicandWidth-1:0] t_word;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic correct;
        logic capture;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic bit_last;
    } t_status;

endpackage

FILE: rtl/core/fpsq_if.sv
interface fpsq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [fpsq_pkg::RadicandWidth-1:0]   radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

interface fpsq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [fpsq_pkg::RootWidth-1:0]       root;

    modport source (output valid, output root, input ready);
    modport sink   (input valid, input root, output ready);
endinterface

FILE: rtl/core/fpsq_ctrl.sv
module fpsq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  fpsq_pkg::t_status i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output fpsq_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_CORR,
        S_PASS2,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PASS1;
                end
            end
            S_PASS1: begin
                o_cmd.step = 1'b1;
                if (i_status.bit_last) begin
                    n_state = S_CORR;
                end
            end
            S_CORR: begin
                o_cmd.correct = 1'b1;
                n_state       = S_PASS2;
            end
            S_PASS2: begin
                o_cmd.step = 1'b1;
                if (i_status.bit_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/fpsq_dp.sv
module fpsq_dp #(
    parameter int unsigned FRAC_BITS = fpsq_pkg::FracBitsDflt
) (
    input  logic                             i_clk,
    input  fpsq_pkg::t_cmd                   i_cmd,
    input  logic [fpsq_pkg::RadicandWidth-1:0] i_radicand,
    output fpsq_pkg::t_status                o_status,
    output logic [fpsq_pkg::RootWidth-1:0]   o_root
);

    localparam fpsq_pkg::t_word Half      = fpsq_pkg::t_word'(1) << (FRAC_BITS - 1);
    localparam fpsq_pkg::t_word Pass2Bit  = fpsq_pkg::t_word'(1) << (FRAC_BITS - 2);

    fpsq_pkg::t_word r_rem;
    fpsq_pkg::t_word r_root;
    fpsq_pkg::t_word r_bit;
    fpsq_pkg::t_word n_rem;
    fpsq_pkg::t_word n_root;
    fpsq_pkg::t_word n_bit;
    logic [fpsq_pkg::RootWidth-1:0] r_result;

    fpsq_pkg::t_word trial;
    fpsq_pkg::t_word rem_less_root;
    logic            rem_big;

    assign trial         = r_root + r_bit;
    // rem - root - 1, so that (x << F) - half becomes ((x - 1) << F) | half
    assign rem_less_root = r_rem + ~r_root;
    assign rem_big       = |r_rem[fpsq_pkg::RadicandWidth-1:FRAC_BITS];

    always_comb begin
        n_rem  = r_rem;
        n_root = r_root;
        n_bit  = r_bit;
        if (i_cmd.load) begin
            n_rem  = i_radicand;
            n_root = '0;
            n_bit  = (|(i_radicand & fpsq_pkg::TopTwelveMask)) ?
                     fpsq_pkg::StartHigh : fpsq_pkg::StartLow;
        end else if (i_cmd.step) begin
            // trial bits above the remainder just leave root at zero
            if (r_rem >= trial) begin
                n_rem  = r_rem - trial;
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit = r_bit >> 2;
        end else if (i_cmd.correct) begin
            if (rem_big) begin
                n_rem  = (rem_less_root << FRAC_BITS) | Half;
                n_root = (r_root << FRAC_BITS) | Half;
            end else begin
                n_rem  = r_rem << FRAC_BITS;
                n_root = r_root << FRAC_BITS;
            end
            n_bit = Pass2Bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
        if (i_cmd.capture) begin
            r_result <= r_root[fpsq_pkg::RootWidth-1:0];
        end
    end

    assign o_status.bit_last = (r_bit[fpsq_pkg::RadicandWidth-1:2] == '0);
    assign o_root            = r_result;

endmodule

FILE: rtl/core/fixed_point_square_root_unit.sv
// fixed-point square root, unsigned, FRAC_BITS fraction bits
// i_in carries one 32-bit radicand per beat, o_out one 24-bit truncated root per beat;
// both use valid/ready, a beat moves when valid and ready are high at a clock edge
// an item is taken only while the unit is idle; it then runs on its own:
//   a load, 16 or 10 restoring steps for the integer root (16 when any of
//   the top twelve radicand bits is set), a scaling/correction step, then
//   FRAC_BITS/2 more steps, and a move of the root into the output register
// a new radicand is taken only once the previous root has moved into the output register,
// so one item is in flight at a time; a single shared add/compare/subtract step
// serves every restoring step of both passes
// the finished root sits in an output register, so when the receiver stalls the
// unit is already idle and accepts the next radicand; that item then waits after
// its final step until the held result is taken
// i_rst_n is synchronous and active low: the unit returns to idle and o_out.valid drops
module fixed_point_square_root_unit #(
    parameter int unsigned FRAC_BITS = fpsq_pkg::FracBitsDflt
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fpsq_in_if.sink           i_in,
    fpsq_out_if.source        o_out
);

    // command and status between the sequencer and the datapath
    fpsq_pkg::t_cmd    cmd;
    fpsq_pkg::t_status status;

    // sequencer: idle, integer pass, correction, fraction pass, hand-off
    fpsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // remainder, partial root and trial bit, plus the output register
    fpsq_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_radicand (i_in.radicand),
        .o_status   (status),
        .o_root     (o_out.root)
    );

endmodule

FILE: test/tb_fixed_point_square_root_unit.sv
module tb_fixed_point_square_root_unit;

    localparam int unsigned FRAC        = fpsq_pkg::FracBitsDflt;
    localparam int unsigned RANDOM_BEATS = 1200;
    localparam int unsigned PHASE_BEATS  = 200;
    localparam int unsigned MAX_IDLE     = 6;
    localparam int unsigned DRAIN_CYCLES = 40;
    // a correct unit never goes this long without moving a beat
    localparam int unsigned STALL_LIMIT  = 2000;

    typedef struct {
        fpsq_pkg::t_word value;
        int unsigned     idle;   // sender gap after this beat
        bit              drain;  // hold this beat back until every root is back
        bit              quiet;  // no idling on either side while this beat is in play
    } t_radicand_item;

    typedef struct {
        fpsq_pkg::t_word                radicand;
        logic [fpsq_pkg::RootWidth-1:0] root;
    } t_root_entry;

    logic i_clk;
    logic i_rst_n;

    fpsq_in_if  radicand_ch ();
    fpsq_out_if root_ch ();

    fixed_point_square_root_unit #(
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (radicand_ch),
        .o_out   (root_ch)
    );

    t_radicand_item pending_radicands[$];
    t_root_entry    pending_roots[$];
    t_radicand_item head_item;
    t_root_entry    oldest_root;
    int unsigned    hold_cycles;
    int unsigned    stall_left;
    int unsigned    stall_draw;
    int unsigned    idle_cycles;
    int unsigned    fail_count;
    bit             quiet_phase;

    // restoring digit loop shared by both passes
    function automatic void run_digits(inout fpsq_pkg::t_word rem,
                                       inout fpsq_pkg::t_word root,
                                       input fpsq_pkg::t_word trial_bit);
        fpsq_pkg::t_word trial;
        while (trial_bit != '0) begin
            trial = root + trial_bit;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root >> 1) + trial_bit;
            end else begin
                root = root >> 1;
            end
            trial_bit = trial_bit >> 2;
        end
    endfunction

    function automatic logic [fpsq_pkg::RootWidth-1:0] predict_root(
        input fpsq_pkg::t_word radicand);
        fpsq_pkg::t_word rem;
        fpsq_pkg::t_word root;
        fpsq_pkg::t_word trial_bit;
        fpsq_pkg::t_word half;
        rem       = radicand;
        root      = '0;
        half      = fpsq_pkg::t_word'(1) << (FRAC - 1);
        trial_bit = ((radicand & fpsq_pkg::TopTwelveMask) != '0) ?
                    fpsq_pkg::StartHigh : fpsq_pkg::StartLow;
        while (trial_bit > rem) trial_bit = trial_bit >> 2;
        run_digits(rem, root, trial_bit);
        // remainder too wide to scale: step to root + 0.5 instead
        if (rem >= (fpsq_pkg::t_word'(1) << FRAC)) begin
            rem  = ((rem - root) << FRAC) - half;
            root = (root << FRAC) + half;
        end else begin
            rem  = rem << FRAC;
            root = root << FRAC;
        end
        run_digits(rem, root, fpsq_pkg::t_word'(1) << (FRAC - 2));
        return root[fpsq_pkg::RootWidth-1:0];
    endfunction

    function automatic int unsigned draw_idle(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // mix of wide, narrow, near-square, top-twelve-boundary and single-bit radicands
    function automatic fpsq_pkg::t_word pick_radicand();
        int unsigned     k;
        fpsq_pkg::t_word sq;
        k  = $urandom_range(0, 65535);
        sq = k * k;
        case ($urandom_range(0, 6))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 32'h000F_FFFF);
            3:    return $urandom_range(0, 255);
            4: begin
                case ($urandom_range(0, 3))
                    0:       return sq;
                    1:       return sq + 2 * k;   // largest remainder for this root
                    2:       return sq - 1;
                    default: return sq + $urandom_range(0, 2 * k);
                endcase
            end
            5:    return 32'h0010_0000 + $urandom_range(0, 64) - 32;
            default: return fpsq_pkg::t_word'(1) << $urandom_range(0, 31);
        endcase
    endfunction

    function automatic void queue_radicand(input fpsq_pkg::t_word value, input bit quiet,
                                           input bit drain);
        t_radicand_item item;
        item.value = value;
        item.idle  = draw_idle(quiet);
        item.drain = drain;
        item.quiet = quiet;
        pending_radicands.push_back(item);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n            = 1'b0;
        radicand_ch.valid    = 1'b0;
        radicand_ch.radicand = '0;
        root_ch.ready        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender: one beat at a time from the pending queue, gap drawn per beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radicand_ch.valid <= 1'b0;
            hold_cycles       <= 0;
            quiet_phase       <= 1'b0;
        end else begin
            if (radicand_ch.valid && radicand_ch.ready) begin
                oldest_root.radicand = radicand_ch.radicand;
                oldest_root.root     = predict_root(radicand_ch.radicand);
                pending_roots.push_back(oldest_root);
            end
            if (!radicand_ch.valid || radicand_ch.ready) begin
                if (hold_cycles != 0) begin
                    hold_cycles       <= hold_cycles - 1;
                    radicand_ch.valid <= 1'b0;
                end else if (pending_radicands.size() != 0 &&
                             !(pending_radicands[0].drain && pending_roots.size() != 0)) begin
                    head_item = pending_radicands.pop_front();
                    radicand_ch.valid    <= 1'b1;
                    radicand_ch.radicand <= head_item.value;
                    hold_cycles          <= head_item.idle;
                    quiet_phase          <= head_item.quiet;
                end else begin
                    radicand_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall drawn after each root beat, then ready stays up until the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_ch.ready <= 1'b0;
            stall_left    <= 0;
        end else if (root_ch.valid && root_ch.ready) begin
            if (pending_roots.size() == 0) begin
                $display("%0t: root beat %h with no radicand outstanding", $time, root_ch.root);
                fail_count++;
            end else begin
                oldest_root = pending_roots.pop_front();
                if (root_ch.root !== oldest_root.root) begin
                    $display("%0t: root mismatch for radicand %h: expected %h, actual %h",
                             $time, oldest_root.radicand, oldest_root.root, root_ch.root);
                    fail_count++;
                end
            end
            stall_draw = draw_idle(quiet_phase);
            root_ch.ready <= (stall_draw == 0);
            stall_left    <= stall_draw;
        end else if (!root_ch.ready) begin
            if (stall_left <= 1) begin
                root_ch.ready <= 1'b1;
                stall_left    <= 0;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((radicand_ch.valid && radicand_ch.ready) || (root_ch.valid && root_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        fail_count = 0;
        // directed: zero, ones, start-bit and top-twelve boundaries, perfect squares,
        // the remainder-correction edge around 32768^2 + 65536
        queue_radicand(32'h0000_0000, 1'b0, 1'b0);
        queue_radicand(32'h0000_0001, 1'b0, 1'b0);
        queue_radicand(32'h0000_0002, 1'b0, 1'b0);
        queue_radicand(32'h0000_0003, 1'b0, 1'b0);
        queue_radicand(32'h0000_0004, 1'b0, 1'b0);
        queue_radicand(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_radicand(32'hFFFF_FFFE, 1'b0, 1'b0);
        queue_radicand(32'hFFFE_0001, 1'b0, 1'b0);
        queue_radicand(32'hFFFE_0000, 1'b0, 1'b0);
        queue_radicand(32'h0010_0000, 1'b0, 1'b0);
        queue_radicand(32'h000F_FFFF, 1'b0, 1'b0);
        queue_radicand(32'h0004_0000, 1'b0, 1'b0);
        queue_radicand(32'h0003_FFFF, 1'b0, 1'b0);
        queue_radicand(32'h4000_0000, 1'b0, 1'b0);
        queue_radicand(32'h3FFF_FFFF, 1'b0, 1'b0);
        queue_radicand(32'h8000_0000, 1'b0, 1'b0);
        queue_radicand(32'h4000_FFFF, 1'b0, 1'b0);
        queue_radicand(32'h4001_0000, 1'b0, 1'b0);
        queue_radicand(32'h0001_0000, 1'b0, 1'b0);
        queue_radicand(32'h0000_FFFF, 1'b0, 1'b0);
        queue_radicand(32'h00FF_FFFF, 1'b0, 1'b0);
        queue_radicand(32'hAAAA_AAAA, 1'b0, 1'b0);
        queue_radicand(32'h5555_5555, 1'b0, 1'b0);

        // random phases; every other one runs without idling, each opens after a full drain
        for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
            queue_radicand(pick_radicand(), ((n / PHASE_BEATS) % 2) == 1,
                           (n % PHASE_BEATS) == 0);
        end

        while (pending_radicands.size() != 0 || radicand_ch.valid ||
               pending_roots.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
